// File: src/nfams_pkg.sv
// Package for the bit-parallel NFA word acceptor.
// Holds default sizes, function codes, register indexes and reset values.
// No dependencies.
package nfams_pkg;

  localparam int NUM_STATES_DEF    = 16;
  localparam int ALPHABET_SIZE_DEF = 4;

  localparam int FUNC_W     = 2;
  localparam int STATE_W    = 4;
  localparam int LETTER_W   = 8;
  localparam int ACT_OUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_ACC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STEP     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LETTER = 2'd1;

  localparam logic [STATE_W-1:0]  START_STATE_RST  = 4'd0;
  localparam logic [LETTER_W-1:0] FIRST_LETTER_RST = 8'd97;

endpackage

// File: src/nfa_membership_stepper_unit.sv
// Bit-parallel NFA word acceptor: input register, then result register to result_valid_o;
// one item accepted every cycle (busy_o is always low); the receiver cannot stall.
// Throughput is set by the single-pass next-state logic: an OR of the edge rows
// of all active states per letter, then a select by letter offset.
// Reset clears the edge table, accepting mask, active set and pipeline valids,
// and loads start state 0 and first_letter 97. Depends on nfams_pkg.
module nfa_membership_stepper_unit #(
  parameter int NUM_STATES    = nfams_pkg::NUM_STATES_DEF,
  parameter int ALPHABET_SIZE = nfams_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [nfams_pkg::FUNC_W-1:0]        func_i,
  input  logic [nfams_pkg::STATE_W-1:0]       src_state_i,
  input  logic [nfams_pkg::STATE_W-1:0]       dst_state_i,
  input  logic [nfams_pkg::LETTER_W-1:0]      letter_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nfams_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nfams_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                result_valid_o,
  output logic                                accepted_o,
  output logic [nfams_pkg::ACT_OUT_W-1:0]     active_set_o,
  output logic                                letter_out_of_range_o
);

  localparam int OFF_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // configuration
  logic [nfams_pkg::STATE_W-1:0]  init_state_q;
  logic [nfams_pkg::LETTER_W-1:0] first_letter_q;

  // input register
  logic                           itm_vld_q;
  logic [nfams_pkg::FUNC_W-1:0]   func_q;
  logic [nfams_pkg::STATE_W-1:0]  src_q;
  logic [nfams_pkg::STATE_W-1:0]  dst_q;
  logic [nfams_pkg::LETTER_W-1:0] letter_q;

  // automaton state
  logic [NUM_STATES-1:0] edge_q [NUM_STATES][ALPHABET_SIZE];
  logic [NUM_STATES-1:0] acc_q, acc_d;
  logic [NUM_STATES-1:0] act_q, act_d;

  // result register
  logic                           res_vld_q;
  logic                           res_acc_q;
  logic [nfams_pkg::ACT_OUT_W-1:0] res_act_q, res_act_d;
  logic                           res_oor_q, res_oor_d;

  // single-pass logic
  logic [nfams_pkg::LETTER_W:0] diff;
  logic                         in_win;
  logic [OFF_W-1:0]             off;
  logic [NUM_STATES-1:0]        col [ALPHABET_SIZE];
  logic [NUM_STATES-1:0]        step_set;
  logic                         src_ok;
  logic                         dst_ok;
  logic                         start_ok;
  logic                         edge_we;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    diff     = {1'b0, letter_q} - {1'b0, first_letter_q};
    in_win   = !diff[nfams_pkg::LETTER_W] &&
               (diff[nfams_pkg::LETTER_W-1:0] < nfams_pkg::LETTER_W'(ALPHABET_SIZE));
    off      = diff[OFF_W-1:0];
    src_ok   = 32'(src_q) < 32'(NUM_STATES);
    dst_ok   = 32'(dst_q) < 32'(NUM_STATES);
    start_ok = 32'(init_state_q) < 32'(NUM_STATES);
    edge_we  = itm_vld_q && (func_q == nfams_pkg::FUNC_ADD_EDGE) && in_win && src_ok && dst_ok;
  end

  always_comb begin
    for (int a = 0; a < ALPHABET_SIZE; a++) begin
      col[a] = '0;
      for (int s = 0; s < NUM_STATES; s++) begin
        col[a] = col[a] | (edge_q[s][a] & {NUM_STATES{act_q[s]}});
      end
    end
    step_set = '0;
    for (int a = 0; a < ALPHABET_SIZE; a++) begin
      if (in_win && (off == OFF_W'(a))) begin
        step_set = step_set | col[a];
      end
    end
  end

  always_comb begin
    act_d     = act_q;
    acc_d     = acc_q;
    res_oor_d = 1'b0;
    case (func_q)
      nfams_pkg::FUNC_ADD_EDGE: begin
        res_oor_d = !in_win;
      end
      nfams_pkg::FUNC_MARK_ACC: begin
        if (src_ok) begin
          acc_d = acc_q | (NUM_STATES'(1) << src_q);
        end
      end
      nfams_pkg::FUNC_BEGIN: begin
        act_d = start_ok ? (NUM_STATES'(1) << init_state_q) : '0;
      end
      nfams_pkg::FUNC_STEP: begin
        act_d     = step_set;
        res_oor_d = !in_win;
      end
      default: begin
        act_d = act_q;
      end
    endcase
  end

  for (genvar i = 0; i < nfams_pkg::ACT_OUT_W; i++) begin : g_act_out
    if (i < NUM_STATES) begin : g_bit
      assign res_act_d[i] = act_d[i];
    end else begin : g_zero
      assign res_act_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_state_q   <= nfams_pkg::START_STATE_RST;
      first_letter_q <= nfams_pkg::FIRST_LETTER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        nfams_pkg::CFG_START_STATE:  init_state_q   <= cfg_data_i[nfams_pkg::STATE_W-1:0];
        nfams_pkg::CFG_FIRST_LETTER: first_letter_q <= cfg_data_i;
        default: begin
          init_state_q <= init_state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_vld_q <= 1'b0;
    end else begin
      itm_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func_q   <= func_i;
      src_q    <= src_state_i;
      dst_q    <= dst_state_i;
      letter_q <= letter_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        for (int a = 0; a < ALPHABET_SIZE; a++) begin
          edge_q[s][a] <= '0;
        end
      end
      acc_q     <= '0;
      act_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= itm_vld_q;
      if (itm_vld_q) begin
        acc_q <= acc_d;
        act_q <= act_d;
      end
      for (int s = 0; s < NUM_STATES; s++) begin
        for (int a = 0; a < ALPHABET_SIZE; a++) begin
          if (edge_we && (32'(src_q) == 32'(s)) && (off == OFF_W'(a))) begin
            edge_q[s][a] <= edge_q[s][a] | (NUM_STATES'(1) << dst_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (itm_vld_q) begin
      res_acc_q <= |(act_d & acc_d);
      res_act_q <= res_act_d;
      res_oor_q <= res_oor_d;
    end
  end

  assign result_valid_o        = res_vld_q;
  assign accepted_o            = res_acc_q;
  assign active_set_o          = res_act_q;
  assign letter_out_of_range_o = res_oor_q;

endmodule
